// File: rtl/mhf_pkg.sv
`default_nettype none

package mhf_pkg;

  localparam int unsigned IN_X_W    = 17;
  localparam int unsigned IN_Y_W    = 16;
  localparam int unsigned OP_X_W    = 33;
  localparam int unsigned OP_Y_W    = 32;
  localparam int unsigned SCALE_SH  = 24;
  localparam int unsigned CORDIC_W  = 59;
  localparam int unsigned Z_W       = 25;
  localparam int unsigned ATAN_W    = 21;
  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned STEP_W    = 5;

  localparam logic [15:0]    FULL_CIRCLE     = 16'd46080;
  localparam logic [Z_W-1:0] HALF_CIRCLE_FINE = 25'd5898240;
  localparam logic [Z_W-1:0] FULL_CIRCLE_FINE = 25'd11796480;
  localparam logic [15:0]    OFFSET_RESET     = 16'd11520;
  localparam logic [15:0]    CALIB_RESET      = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_INIT,
    ST_STEP,
    ST_NORM,
    ST_ROUND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic eval;
    logic init;
    logic step;
    logic norm;
    logic round;
    logic done;
  } ctrl_t;

  // round(atan(2^-i) * 32768 * 45 / 45) in 1/32768 degree
  function automatic logic [ATAN_W-1:0] atan_fine(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 21'd1474560;
      5'd1:    v = 21'd870484;
      5'd2:    v = 21'd459940;
      5'd3:    v = 21'd233473;
      5'd4:    v = 21'd117189;
      5'd5:    v = 21'd58652;
      5'd6:    v = 21'd29333;
      5'd7:    v = 21'd14667;
      5'd8:    v = 21'd7334;
      5'd9:    v = 21'd3667;
      5'd10:   v = 21'd1833;
      5'd11:   v = 21'd917;
      5'd12:   v = 21'd458;
      5'd13:   v = 21'd229;
      5'd14:   v = 21'd115;
      5'd15:   v = 21'd57;
      5'd16:   v = 21'd29;
      5'd17:   v = 21'd14;
      5'd18:   v = 21'd7;
      5'd19:   v = 21'd4;
      5'd20:   v = 21'd2;
      5'd21:   v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mhf_ram.sv
`default_nettype none

module mhf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/magnetometer_heading_filter.sv
// magnetometer heading filter
// slave stream: one transaction per sensor reading; tdata holds raw_x and raw_y,
// tuser holds read_ok and calibrating. master stream: one transaction per heading,
// tdata holds yaw (1/128 degree, 0 to below 360), tuser holds from_calibration.
// normal readings go through a moving average of WINDOW_LEN samples per axis
// (raw value until the window has filled once), then an iterative vectoring
// cordic gives atan2, and the stored heading offset is added modulo 360 degrees.
// calibration readings are summed until calib_samples attempts are counted; the
// heading of the sums becomes the new offset and is sent with from_calibration set.
// failed normal reads and unfinished calibration reads give no transaction.
// sequence: accept, evaluate, init, CORDIC_STEPS (at most 24) cordic steps,
// normalize, round and output load before tvalid, one cordic step a cycle on
// the shared add/shift unit; a reading is accepted only once the sequencer is
// through with the last one, as s_axis_tready is high only while the sequencer
// is idle; an item that causes no result returns the sequencer to idle straight
// after evaluation.
// a result waits in the output register while the master side stalls; the next
// reading is accepted meanwhile and its result waits until the register frees.
// reset: window empty, offset 90 degrees, calib_samples 1000, no calibration run.
// cfg_we_i writes calib_samples (0 acts as 1); write only while the block is idle.
`default_nettype none

module magnetometer_heading_filter import mhf_pkg::*; #(
  parameter int unsigned WINDOW_LEN   = 8,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // raw_x [15:0], raw_y [31:16]
  input  wire logic [1:0]  s_axis_tuser,  // read_ok [0], calibrating [1]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,  // yaw [15:0]
  output logic      [0:0]  m_axis_tuser   // from_calibration [0]
);

  localparam int unsigned ADDR_W    = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_X_W   = IN_X_W + $clog2(WINDOW_LEN);
  localparam int unsigned SUM_Y_W   = IN_Y_W + $clog2(WINDOW_LEN);
  localparam int unsigned STEPS_RUN = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(WINDOW_LEN - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_RUN - 1);

  state_e state_q, state_d;
  ctrl_t  ctrl;

  logic [15:0] calib_samples_q;
  logic [15:0] heading_offset_q;
  logic [15:0] calib_count_q;
  logic signed [OP_X_W-1:0] calib_sum_x_q;
  logic signed [OP_Y_W-1:0] calib_sum_y_q;
  logic signed [SUM_X_W-1:0] x_sum_q;
  logic signed [SUM_Y_W-1:0] y_sum_q;
  logic [ADDR_W-1:0] slot_q;
  logic window_full_q;

  logic signed [IN_X_W-1:0] in_x_q;
  logic signed [IN_Y_W-1:0] in_y_q;
  logic in_ok_q;
  logic in_cal_q;

  logic signed [OP_X_W-1:0] op_x_q;
  logic signed [OP_Y_W-1:0] op_y_q;
  logic signed [CORDIC_W-1:0] cx_q;
  logic signed [CORDIC_W-1:0] cy_q;
  logic signed [Z_W-1:0] z_q;
  logic [STEP_W-1:0] step_q;
  logic zero_q;
  logic [23:0] total_q;
  logic [15:0] h_q;

  logic out_valid_q;
  logic [15:0] out_yaw_q;
  logic out_cal_q;

  // evaluation of the latched reading
  logic [15:0] calib_count_inc;
  logic [15:0] calib_target;
  logic calib_end;
  logic signed [OP_X_W-1:0] calib_sum_x_new;
  logic signed [OP_Y_W-1:0] calib_sum_y_new;
  logic [IN_X_W+IN_Y_W-1:0] win_rdata;
  logic signed [IN_X_W-1:0] old_x;
  logic signed [IN_Y_W-1:0] old_y;
  logic signed [SUM_X_W-1:0] x_sum_new;
  logic signed [SUM_Y_W-1:0] y_sum_new;
  logic slot_wrap;
  logic full_new;
  logic win_we;

  // shared cordic step unit
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [Z_W-1:0] atan_z;
  logic signed [CORDIC_W-1:0] init_x;
  logic signed [CORDIC_W-1:0] init_y;
  logic signed [Z_W-1:0] total_w;
  logic [24:0] round_sum;
  logic [16:0] h_raw;
  logic [16:0] yaw_sum;
  logic [15:0] yaw_res;
  logic out_load;

  assign calib_count_inc = calib_count_q + 16'd1;
  assign calib_target    = (calib_samples_q == 16'd0) ? 16'd1 : calib_samples_q;
  assign calib_end       = (calib_count_inc >= calib_target);
  assign calib_sum_x_new = in_ok_q ? (calib_sum_x_q + OP_X_W'(in_x_q)) : calib_sum_x_q;
  assign calib_sum_y_new = in_ok_q ? (calib_sum_y_q + OP_Y_W'(in_y_q)) : calib_sum_y_q;

  // slots not yet written since reset are read as zero; they lie ahead of the slot pointer
  assign old_x = window_full_q ? win_rdata[IN_X_W-1:0] : '0;
  assign old_y = window_full_q ? win_rdata[IN_X_W+IN_Y_W-1:IN_X_W] : '0;
  assign x_sum_new = x_sum_q - SUM_X_W'(old_x) + SUM_X_W'(in_x_q);
  assign y_sum_new = y_sum_q - SUM_Y_W'(old_y) + SUM_Y_W'(in_y_q);
  assign slot_wrap = (slot_q == SLOT_LAST);
  assign full_new  = window_full_q | slot_wrap;
  assign win_we    = ctrl.eval & ~in_cal_q & in_ok_q;

  mhf_ram #(
    .WIDTH(IN_X_W + IN_Y_W),
    .DEPTH(WINDOW_LEN)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(slot_q),
    .wdata_i({in_y_q, in_x_q}),
    .raddr_i(slot_q),
    .rdata_o(win_rdata)
  );

  assign init_x = {{(CORDIC_W-SCALE_SH-OP_X_W){op_x_q[OP_X_W-1]}}, op_x_q, SCALE_SH'(0)};
  assign init_y = {{(CORDIC_W-SCALE_SH-OP_Y_W){op_y_q[OP_Y_W-1]}}, op_y_q, SCALE_SH'(0)};
  assign xs     = cx_q >>> step_q;
  assign ys     = cy_q >>> step_q;
  assign atan_z = Z_W'(atan_fine(step_q));
  assign total_w = (z_q < 0) ? (z_q + FULL_CIRCLE_FINE) : z_q;

  assign round_sum = {1'b0, total_q} + 25'd128;
  assign h_raw     = round_sum[24:8];
  assign yaw_sum   = {1'b0, h_q} + {1'b0, heading_offset_q};
  assign yaw_res   = in_cal_q ? h_q :
                     ((yaw_sum >= {1'b0, FULL_CIRCLE}) ? 16'(yaw_sum - {1'b0, FULL_CIRCLE})
                                                       : yaw_sum[15:0]);
  assign out_load  = ctrl.done & (~out_valid_q | m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (in_cal_q) begin
          state_d = calib_end ? ST_INIT : ST_IDLE;
        end else begin
          state_d = in_ok_q ? ST_INIT : ST_IDLE;
        end
      end
      ST_INIT: state_d = ST_STEP;
      ST_STEP: begin
        if (step_q == STEP_LAST) state_d = ST_NORM;
      end
      ST_NORM:  state_d = ST_ROUND;
      ST_ROUND: state_d = ST_DONE;
      ST_DONE: begin
        if (~out_valid_q | m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE:  ctrl.in_ready = 1'b1;
      ST_EVAL:  ctrl.eval     = 1'b1;
      ST_INIT:  ctrl.init     = 1'b1;
      ST_STEP:  ctrl.step     = 1'b1;
      ST_NORM:  ctrl.norm     = 1'b1;
      ST_ROUND: ctrl.round    = 1'b1;
      ST_DONE:  ctrl.done     = 1'b1;
      default:  ctrl          = '0;
    endcase
  end

  assign s_axis_tready = ctrl.in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      calib_samples_q  <= CALIB_RESET;
      heading_offset_q <= OFFSET_RESET;
      calib_count_q    <= '0;
      calib_sum_x_q    <= '0;
      calib_sum_y_q    <= '0;
      x_sum_q          <= '0;
      y_sum_q          <= '0;
      slot_q           <= '0;
      window_full_q    <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        calib_samples_q <= cfg_wdata_i;
      end
      if (ctrl.eval) begin
        if (in_cal_q) begin
          if (calib_end) begin
            calib_count_q <= '0;
            calib_sum_x_q <= '0;
            calib_sum_y_q <= '0;
          end else begin
            calib_count_q <= calib_count_inc;
            calib_sum_x_q <= calib_sum_x_new;
            calib_sum_y_q <= calib_sum_y_new;
          end
        end else begin
          calib_count_q <= '0;
          calib_sum_x_q <= '0;
          calib_sum_y_q <= '0;
          if (in_ok_q) begin
            x_sum_q       <= x_sum_new;
            y_sum_q       <= y_sum_new;
            slot_q        <= slot_wrap ? '0 : slot_q + ADDR_W'(1);
            window_full_q <= full_new;
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (in_cal_q) heading_offset_q <= yaw_res;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl.in_ready & s_axis_tvalid) begin
      in_x_q   <= -IN_X_W'(signed'(s_axis_tdata[15:0]));
      in_y_q   <= s_axis_tdata[31:16];
      in_ok_q  <= s_axis_tuser[0];
      in_cal_q <= s_axis_tuser[1];
    end
    if (ctrl.eval) begin
      if (in_cal_q) begin
        op_x_q <= calib_sum_x_new;
        op_y_q <= calib_sum_y_new;
      end else if (full_new) begin
        op_x_q <= OP_X_W'(x_sum_new);
        op_y_q <= OP_Y_W'(y_sum_new);
      end else begin
        op_x_q <= OP_X_W'(in_x_q);
        op_y_q <= OP_Y_W'(in_y_q);
      end
    end
    if (ctrl.init) begin
      zero_q <= (op_x_q == '0) && (op_y_q == '0);
      step_q <= '0;
      if (op_x_q < 0) begin
        cx_q <= -init_x;
        cy_q <= -init_y;
        z_q  <= HALF_CIRCLE_FINE;
      end else begin
        cx_q <= init_x;
        cy_q <= init_y;
        z_q  <= '0;
      end
    end
    if (ctrl.step) begin
      step_q <= step_q + STEP_W'(1);
      if (cy_q > 0) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        z_q  <= z_q + atan_z;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        z_q  <= z_q - atan_z;
      end
    end
    if (ctrl.norm) begin
      total_q <= total_w[23:0];
    end
    if (ctrl.round) begin
      if (zero_q) begin
        h_q <= '0;
      end else if (h_raw >= {1'b0, FULL_CIRCLE}) begin
        h_q <= 16'(h_raw - {1'b0, FULL_CIRCLE});
      end else begin
        h_q <= h_raw[15:0];
      end
    end
    if (out_load) begin
      out_yaw_q <= yaw_res;
      out_cal_q <= in_cal_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_yaw_q;
  assign m_axis_tuser[0] = out_cal_q;

`ifndef NO_ASSERTIONS
  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata < FULL_CIRCLE))
    else $error("yaw out of range");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (step_q <= STEP_LAST))
    else $error("cordic step counter overran");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_EVAL))
    else $error("accepted reading not evaluated");

  a_offset_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && in_cal_q) |=> (heading_offset_q == m_axis_tdata && m_axis_tuser[0]))
    else $error("calibration result not stored as offset");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_LAST)
    else $error("window slot out of range");
`endif

endmodule

`default_nettype wire

// File: dv/heading_filter_checker.sv
module heading_filter_checker import mhf_pkg::*; #(
  parameter int unsigned WINDOW_LEN   = 8,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [31:0]       s_tdata_i,   // raw_x [15:0], raw_y [31:16]
  input  logic [1:0]        s_tuser_i,   // read_ok [0], calibrating [1]
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [15:0]       m_tdata_i,   // yaw [15:0]
  input  logic [0:0]        m_tuser_i,   // from_calibration [0]
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  localparam int unsigned SUM_XW    = 17 + $clog2(WINDOW_LEN);
  localparam int unsigned SUM_YW    = 16 + $clog2(WINDOW_LEN);
  localparam longint      TURN      = longint'(FULL_CIRCLE);
  localparam longint      TURN_FINE = longint'(FULL_CIRCLE_FINE);
  localparam longint      HALF_FINE = longint'(HALF_CIRCLE_FINE);

  typedef struct packed {
    logic [15:0] yaw;
    logic        from_cal;
  } heading_t;

  heading_t expected_headings[$];

  logic signed [16:0]       x_hist [WINDOW_LEN];
  logic signed [15:0]       y_hist [WINDOW_LEN];
  logic signed [SUM_XW-1:0] x_sum;
  logic signed [SUM_YW-1:0] y_sum;
  int unsigned              slot;
  bit                       filled;
  logic [15:0]              offset;
  logic [15:0]              samples;
  logic [15:0]              cal_count;
  logic signed [32:0]       cal_x;
  logic signed [31:0]       cal_y;
  int unsigned              failures;

  // arctan(2^-i) in 1/32768 degree
  function automatic longint arctan_step(input int i);
    case (i)
      0:       return 1474560;
      1:       return 870484;
      2:       return 459940;
      3:       return 233473;
      4:       return 117189;
      5:       return 58652;
      6:       return 29333;
      7:       return 14667;
      8:       return 7334;
      9:       return 3667;
      10:      return 1833;
      11:      return 917;
      12:      return 458;
      13:      return 229;
      14:      return 115;
      15:      return 57;
      16:      return 29;
      17:      return 14;
      18:      return 7;
      19:      return 4;
      20:      return 2;
      21:      return 1;
      default: return 0;
    endcase
  endfunction

  // vectoring cordic atan2 in 1/128 degree
  function automatic logic [15:0] heading_of(input longint vx, input longint vy);
    longint      ax;
    longint      ay;
    longint      sx;
    longint      sy;
    longint      angle;
    longint      h;
    int unsigned steps;
    if (vx == 0 && vy == 0) return '0;
    ax = vx * 64'sd16777216;
    ay = vy * 64'sd16777216;
    angle = 0;
    if (ax < 0) begin
      ax = -ax;
      ay = -ay;
      angle = HALF_FINE;
    end
    steps = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    for (int i = 0; i < steps; i++) begin
      sx = ax >>> i;
      sy = ay >>> i;
      if (ay > 0) begin
        ax = ax + sy;
        ay = ay - sx;
        angle = angle + arctan_step(i);
      end else begin
        ax = ax - sy;
        ay = ay + sx;
        angle = angle - arctan_step(i);
      end
    end
    while (angle < 0) angle = angle + TURN_FINE;
    while (angle >= TURN_FINE) angle = angle - TURN_FINE;
    h = (angle + 128) >>> 8;
    if (h >= TURN) h = h - TURN;
    return h[15:0];
  endfunction

  task automatic clear_filter_state();
    for (int i = 0; i < WINDOW_LEN; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    x_sum = '0;
    y_sum = '0;
    slot = 0;
    filled = 1'b0;
    offset = OFFSET_RESET;
    samples = CALIB_RESET;
    cal_count = '0;
    cal_x = '0;
    cal_y = '0;
    expected_headings.delete();
  endtask

  task automatic take_reading(input logic [31:0] data, input logic [1:0] user);
    logic signed [16:0] xn;
    logic signed [15:0] yn;
    logic [16:0]        target;
    logic [15:0]        h;
    int unsigned        wrapped;
    longint             fx;
    longint             fy;
    xn = -$signed(data[15:0]);
    yn = data[31:16];
    if (user[1]) begin
      cal_count = cal_count + 1'b1;
      if (user[0]) begin
        cal_x = cal_x + xn;
        cal_y = cal_y + yn;
      end
      target = (samples == 0) ? 17'd1 : {1'b0, samples};
      if ({1'b0, cal_count} < target) return;
      h = heading_of(cal_x, cal_y);
      offset = h;
      cal_count = '0;
      cal_x = '0;
      cal_y = '0;
      expected_headings.push_back('{yaw: h, from_cal: 1'b1});
      return;
    end
    // a normal reading abandons any partial calibration run
    cal_count = '0;
    cal_x = '0;
    cal_y = '0;
    if (!user[0]) return;
    x_sum = x_sum - x_hist[slot] + xn;
    y_sum = y_sum - y_hist[slot] + yn;
    x_hist[slot] = xn;
    y_hist[slot] = yn;
    slot++;
    if (slot >= WINDOW_LEN) begin
      slot = 0;
      filled = 1'b1;
    end
    if (filled) begin
      fx = x_sum;
      fy = y_sum;
    end else begin
      fx = xn;
      fy = yn;
    end
    wrapped = heading_of(fx, fy);
    wrapped = (wrapped + offset) % FULL_CIRCLE;
    expected_headings.push_back('{yaw: wrapped[15:0], from_cal: 1'b0});
  endtask

  task automatic check_heading(input logic [15:0] yaw, input logic from_cal);
    heading_t exp_h;
    if (expected_headings.size() == 0) begin
      if (failures < 10)
        $display("unexpected heading: yaw %0d from_calibration %0d", yaw, from_cal);
      failures++;
      return;
    end
    exp_h = expected_headings.pop_front();
    if (yaw !== exp_h.yaw || from_cal !== exp_h.from_cal) begin
      if (failures < 10)
        $display("heading mismatch: expected yaw %0d cal %0d, got yaw %0d cal %0d",
                 exp_h.yaw, exp_h.from_cal, yaw, from_cal);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_filter_state();
      failures = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // results first, so an input taken at the same edge cannot match them
      if (m_tvalid_i && m_tready_i) check_heading(m_tdata_i, m_tuser_i[0]);
      if (cfg_we_i) samples = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) take_reading(s_tdata_i, s_tuser_i);
      fail_count_o <= failures;
      pending_o <= expected_headings.size();
    end
  end

endmodule

// File: dv/magnetometer_heading_filter_test.sv
module magnetometer_heading_filter_test import mhf_pkg::*;;

  localparam int unsigned WINDOW_LEN      = 8;
  localparam int unsigned CORDIC_STEPS    = 16;
  localparam int unsigned DRAIN_CYCLES    = 2 * (CORDIC_STEPS + 5);
  localparam int unsigned RX_HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned ITEMS_PER_PHASE = 550;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [15:0] cfg_wdata     = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [15:0] m_axis_tdata;
  wire  [0:0]  m_axis_tuser;

  int unsigned tx_idle_pct   = 25;
  int unsigned rx_idle_pct   = 67;
  bit          rx_hold_req   = 1'b0;
  int unsigned calib_target  = CALIB_RESET;
  int unsigned cycle_count   = 0;
  int unsigned fail_count;
  int unsigned pending;

  always #5 clk_i = ~clk_i;

  magnetometer_heading_filter #(
    .WINDOW_LEN  (WINDOW_LEN),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  heading_filter_checker #(
    .WINDOW_LEN  (WINDOW_LEN),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off when requested
  initial begin
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < RX_HOLD_CYCLES; n++) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [15:0] rand_count();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'hffff;
          3:       return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_reading(input logic [15:0] raw_x, input logic [15:0] raw_y,
                              input logic read_ok, input logic calibrating);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {raw_y, raw_x};
    s_axis_tuser <= {calibrating, read_ok};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering and let every outstanding heading come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_calib_samples(input logic [15:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    calib_target = (value == 0) ? 1 : value;
  endtask

  task automatic random_phase(input int unsigned n_items, input bit do_hold,
                              input bit do_pause);
    int unsigned counted;
    int unsigned roll;
    int unsigned len;
    bit          hold_done;
    bit          pause_done;
    counted = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    while (counted < n_items) begin
      if (do_hold && !hold_done && counted >= n_items / 3) begin
        rx_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (do_pause && !pause_done && counted >= n_items / 2) begin
        drain();
        pause_done = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 55) begin
        send_reading(rand_count(), rand_count(), 1'b1, 1'b0);
        counted++;
      end else if (roll < 63) begin
        send_reading(rand_count(), rand_count(), 1'b0, 1'b0);
        counted++;
      end else if (roll < 92) begin
        // complete calibration run, occasional failed reads
        for (int k = 0; k < calib_target; k++)
          send_reading(rand_count(), rand_count(), $urandom_range(7) != 0, 1'b1);
        counted += calib_target;
      end else begin
        // run cut short by a normal reading
        len = $urandom_range(calib_target - 1, 0);
        for (int k = 0; k < len; k++)
          send_reading(rand_count(), rand_count(), $urandom_range(7) != 0, 1'b1);
        send_reading(rand_count(), rand_count(), 1'b1, 1'b0);
        counted += len + 1;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // raw pass-through while the window fills, extremes and zero vector
    send_reading(16'h0000, 16'h0000, 1'b1, 1'b0);
    send_reading(16'h8000, 16'h0000, 1'b1, 1'b0);
    send_reading(16'h7fff, 16'h0000, 1'b1, 1'b0);
    send_reading(16'h0000, 16'h7fff, 1'b1, 1'b0);
    send_reading(16'h0000, 16'h8000, 1'b1, 1'b0);
    send_reading(16'h8000, 16'h8000, 1'b1, 1'b0);
    send_reading(16'h7fff, 16'h7fff, 1'b1, 1'b0);
    send_reading(16'h5a5a, 16'ha5a5, 1'b0, 1'b0);
    send_reading(16'h0001, 16'hffff, 1'b1, 1'b0);
    // window now full, averaged from here on
    send_reading(16'h007b, 16'hfe38, 1'b1, 1'b0);

    // zero sample count acts as one
    load_calib_samples(16'd0);
    send_reading(16'hfc18, 16'h0320, 1'b1, 1'b1);

    load_calib_samples(16'd3);
    send_reading(16'h1000, 16'h2000, 1'b1, 1'b1);
    send_reading(16'h7fff, 16'h8000, 1'b0, 1'b1);
    send_reading(16'hf000, 16'h0100, 1'b1, 1'b1);
    // every read of the run failed
    send_reading(16'h1234, 16'h4321, 1'b0, 1'b1);
    send_reading(16'h8000, 16'h7fff, 1'b0, 1'b1);
    send_reading(16'hffff, 16'hffff, 1'b0, 1'b1);
    // normal reading interrupts a run, next run starts fresh
    send_reading(16'h0400, 16'h0400, 1'b1, 1'b1);
    send_reading(16'h0200, 16'hfe00, 1'b1, 1'b0);
    send_reading(16'h8000, 16'h8000, 1'b1, 1'b1);
    send_reading(16'h8000, 16'h8000, 1'b1, 1'b1);
    send_reading(16'h8000, 16'h8000, 1'b1, 1'b1);

    load_calib_samples(16'hffff);
    send_reading(16'h0100, 16'h0200, 1'b1, 1'b1);
    send_reading(16'h0300, 16'h0400, 1'b1, 1'b1);
    send_reading(16'h0500, 16'h0600, 1'b1, 1'b0);

    load_calib_samples(16'($urandom_range(6, 2)));
    random_phase(ITEMS_PER_PHASE, 1'b1, 1'b0);

    tx_idle_pct = 67;
    rx_idle_pct = 25;
    load_calib_samples(16'd1);
    random_phase(ITEMS_PER_PHASE, 1'b0, 1'b1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_calib_samples(16'($urandom_range(20, 7)));
    random_phase(ITEMS_PER_PHASE, 1'b0, 1'b0);

    drain();
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
rtl/mhf_pkg.sv
rtl/mhf_ram.sv
rtl/magnetometer_heading_filter.sv
dv/heading_filter_checker.sv
dv/magnetometer_heading_filter_test.sv
